@@ rtl/core/iir_direct_form_one_filter_macros.svh @@
// Assertion helpers shared by the filter RTL.
`ifndef IIR_DIRECT_FORM_ONE_FILTER_MACROS_SVH
`define IIR_DIRECT_FORM_ONE_FILTER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define IIR_DF1_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define IIR_DF1_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/iir_df1_pkg.sv @@
package iir_df1_pkg;

  // Coefficients are signed Q5.10, four to a configuration word.
  localparam int COEF_W        = 16;
  localparam int CFG_DATA_W    = 64;
  localparam int CFG_IDX_W     = 2;
  localparam int COEFS_PER_REG = CFG_DATA_W / COEF_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FF_LOW  = 2'd0,
    CFG_FF_HIGH = 2'd1,
    CFG_FB_LOW  = 2'd2,
    CFG_FB_HIGH = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_ROUND
  } state_e;

  // History shift register control.
  typedef struct packed {
    logic load_x;
    logic rotate;
    logic push_y;
  } hist_ctrl_t;

  // Bit-serial multiply-accumulate control.
  typedef struct packed {
    logic step;
    logic first;
  } mac_ctrl_t;

endpackage

@@ rtl/core/iir_df1_if.sv @@
interface iir_df1_in_if #(
  parameter int SampleWidth = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SampleWidth-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface iir_df1_out_if #(
  parameter int SampleWidth = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SampleWidth-1:0] sample_out;
  logic                          clipped;

  modport source (output valid, output sample_out, output clipped, input ready);
  modport sink   (input valid, input sample_out, input clipped, output ready);
endinterface

@@ rtl/core/iir_df1_hist.sv @@
module iir_df1_hist #(
  parameter int TAPS         = 8,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  iir_df1_pkg::hist_ctrl_t        ctrl_i,
  input  logic signed [SAMPLE_WIDTH-1:0] x_new_i,
  input  logic signed [SAMPLE_WIDTH-1:0] y_new_i,
  output logic [TAPS-1:0]                x_bits_o,
  output logic [TAPS-1:1]                y_bits_o
);

  // x_q[k] is the input k samples old, y_q[k] the output k samples old.
  logic [SAMPLE_WIDTH-1:0] x_q [TAPS];
  logic [SAMPLE_WIDTH-1:0] x_d [TAPS];
  logic [SAMPLE_WIDTH-1:0] y_q [1:TAPS-1];
  logic [SAMPLE_WIDTH-1:0] y_d [1:TAPS-1];

  always_comb begin
    for (int k = 0; k < TAPS; k++) begin
      x_d[k] = x_q[k];
      if (ctrl_i.load_x) begin
        x_d[k] = (k == 0) ? x_new_i : x_q[(k == 0) ? 0 : k - 1];
      end else if (ctrl_i.rotate) begin
        x_d[k] = {x_q[k][SAMPLE_WIDTH-2:0], x_q[k][SAMPLE_WIDTH-1]};
      end
    end
    for (int k = 1; k < TAPS; k++) begin
      y_d[k] = y_q[k];
      if (ctrl_i.push_y) begin
        y_d[k] = (k == 1) ? y_new_i : y_q[(k == 1) ? 1 : k - 1];
      end else if (ctrl_i.rotate) begin
        y_d[k] = {y_q[k][SAMPLE_WIDTH-2:0], y_q[k][SAMPLE_WIDTH-1]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < TAPS; k++) begin
        x_q[k] <= '0;
      end
      for (int k = 1; k < TAPS; k++) begin
        y_q[k] <= '0;
      end
    end else begin
      x_q <= x_d;
      y_q <= y_d;
    end
  end

  // Present the most significant bit of every tap; rotation walks down the word.
  always_comb begin
    for (int k = 0; k < TAPS; k++) begin
      x_bits_o[k] = x_q[k][SAMPLE_WIDTH-1];
    end
    for (int k = 1; k < TAPS; k++) begin
      y_bits_o[k] = y_q[k][SAMPLE_WIDTH-1];
    end
  end

endmodule

@@ rtl/core/iir_df1_mac.sv @@
module iir_df1_mac #(
  parameter int TAPS  = 8,
  parameter int ACC_W = 39
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_we_i,
  input  logic [iir_df1_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [iir_df1_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  iir_df1_pkg::mac_ctrl_t                  ctrl_i,
  input  logic [TAPS-1:0]                         x_bits_i,
  input  logic [TAPS-1:1]                         y_bits_i,
  output logic signed [ACC_W-1:0]                 acc_o
);

  localparam int COEF_W = iir_df1_pkg::COEF_W;
  localparam int PART_W = COEF_W + $clog2(TAPS) + 1;

  logic signed [COEF_W-1:0] b_q [TAPS];
  logic signed [COEF_W-1:0] a_q [1:TAPS-1];

  // Coefficient bank: each tap picks its lane out of its configuration word.
  for (genvar k = 0; k < TAPS; k++) begin : g_ff_coef
    localparam iir_df1_pkg::cfg_reg_e FfReg = (k < iir_df1_pkg::COEFS_PER_REG) ?
                                              iir_df1_pkg::CFG_FF_LOW :
                                              iir_df1_pkg::CFG_FF_HIGH;
    localparam int Lane = k % iir_df1_pkg::COEFS_PER_REG;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        b_q[k] <= '0;
      end else if (cfg_we_i && cfg_idx_i == FfReg) begin
        b_q[k] <= cfg_wdata_i[COEF_W*Lane +: COEF_W];
      end
    end
  end

  for (genvar k = 1; k < TAPS; k++) begin : g_fb_coef
    localparam iir_df1_pkg::cfg_reg_e FbReg = (k < iir_df1_pkg::COEFS_PER_REG) ?
                                              iir_df1_pkg::CFG_FB_LOW :
                                              iir_df1_pkg::CFG_FB_HIGH;
    localparam int Lane = k % iir_df1_pkg::COEFS_PER_REG;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        a_q[k] <= '0;
      end else if (cfg_we_i && cfg_idx_i == FbReg) begin
        a_q[k] <= cfg_wdata_i[COEF_W*Lane +: COEF_W];
      end
    end
  end

  // Partial products of one bit plane: add each coefficient whose sample bit is set.
  logic signed [PART_W-1:0] ff_sum;
  logic signed [PART_W-1:0] fb_sum;

  always_comb begin
    ff_sum = '0;
    for (int k = 0; k < TAPS; k++) begin
      ff_sum = ff_sum + (x_bits_i[k] ? PART_W'(b_q[k]) : '0);
    end
    fb_sum = '0;
    for (int k = 1; k < TAPS; k++) begin
      fb_sum = fb_sum + (y_bits_i[k] ? PART_W'(a_q[k]) : '0);
    end
  end

  logic signed [PART_W-1:0] ff_q;
  logic signed [PART_W-1:0] fb_q;
  logic                     pvld_q;
  logic                     pfirst_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pvld_q   <= 1'b0;
      pfirst_q <= 1'b0;
    end else begin
      pvld_q   <= ctrl_i.step;
      pfirst_q <= ctrl_i.first;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.step) begin
      ff_q <= ff_sum;
      fb_q <= fb_sum;
    end
  end

  // Most significant plane first: its weight is negative, the rest double and add.
  logic signed [ACC_W-1:0] diff;
  logic signed [ACC_W-1:0] acc_q;
  logic signed [ACC_W-1:0] acc_d;

  always_comb begin
    diff  = ACC_W'(ff_q) - ACC_W'(fb_q);
    acc_d = pfirst_q ? -diff : (acc_q <<< 1) + diff;
  end

  always_ff @(posedge clk_i) begin
    if (pvld_q) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

@@ rtl/core/iir_direct_form_one_filter.sv @@
// Direct form I IIR filter, TAPS taps, on signed SAMPLE_WIDTH-bit samples with
// signed Q5.10 coefficients loaded through the configuration port (feedforward
// taps in words 0 and 1, feedback taps in words 2 and 3, leading feedback tap
// ignored). Each sample is worked bit-serially: the histories sit in rotating
// shift registers and one bit plane of all taps is multiplied and summed per
// cycle, most significant bit first. A request passes through a load step,
// SAMPLE_WIDTH bit planes, a step that drains the accumulator and one that
// rounds and saturates before the next request is accepted. The result lands
// in an output register, so a new sample is taken while the previous result
// still waits; the round step stalls only if that register is still full.
// Histories and coefficients clear on reset. Write the configuration only
// while the filter is idle.
`include "iir_direct_form_one_filter_macros.svh"

module iir_direct_form_one_filter #(
  parameter int TAPS           = 8,
  parameter int SAMPLE_WIDTH   = 16,
  parameter int COEF_FRAC_BITS = 10
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  iir_df1_in_if.sink                          in_i,
  iir_df1_out_if.source                       out_o,
  input  logic                                cfg_we_i,
  input  logic [iir_df1_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [iir_df1_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);

  localparam int ACC_W = SAMPLE_WIDTH + iir_df1_pkg::COEF_W + $clog2(TAPS) + 2;
  localparam int CNT_W = $clog2(SAMPLE_WIDTH);

  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) << (COEF_FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] SAT_HI   = (ACC_W'(1) << (SAMPLE_WIDTH - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] SAT_LO   = -(ACC_W'(1) << (SAMPLE_WIDTH - 1));

  iir_df1_pkg::state_e     state_q, state_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  iir_df1_pkg::hist_ctrl_t hist_ctrl;
  iir_df1_pkg::mac_ctrl_t  mac_ctrl;

  logic [TAPS-1:0]         x_bits;
  logic [TAPS-1:1]         y_bits;
  logic signed [ACC_W-1:0] acc;

  logic                           out_vld_q;
  logic signed [SAMPLE_WIDTH-1:0] out_sample_q;
  logic                           out_clip_q;
  logic                           out_load;
  logic                           in_fire;

  // Round half up, shift arithmetically and clamp to the sample range.
  logic signed [ACC_W-1:0]        rnd_sum;
  logic signed [ACC_W-1:0]        rnd_shift;
  logic                           sat_over;
  logic                           sat_under;
  logic signed [SAMPLE_WIDTH-1:0] sat_val;

  always_comb begin
    rnd_sum   = acc + RND_HALF;
    rnd_shift = rnd_sum >>> COEF_FRAC_BITS;
    sat_over  = rnd_shift > SAT_HI;
    sat_under = rnd_shift < SAT_LO;
    if (sat_over) begin
      sat_val = SAT_HI[SAMPLE_WIDTH-1:0];
    end else if (sat_under) begin
      sat_val = SAT_LO[SAMPLE_WIDTH-1:0];
    end else begin
      sat_val = rnd_shift[SAMPLE_WIDTH-1:0];
    end
  end

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_load = (state_q == iir_df1_pkg::ST_ROUND) && (!out_vld_q || out_o.ready);

  // Sequencer: load, walk the bit planes, drain, round.
  always_comb begin
    state_d          = state_q;
    cnt_d            = cnt_q;
    in_i.ready       = 1'b0;
    hist_ctrl        = '0;
    mac_ctrl         = '0;
    case (state_q)
      iir_df1_pkg::ST_IDLE: begin
        in_i.ready       = 1'b1;
        hist_ctrl.load_x = in_i.valid;
        if (in_i.valid) begin
          state_d = iir_df1_pkg::ST_RUN;
          cnt_d   = '0;
        end
      end
      iir_df1_pkg::ST_RUN: begin
        hist_ctrl.rotate = 1'b1;
        mac_ctrl.step    = 1'b1;
        mac_ctrl.first   = (cnt_q == '0);
        cnt_d            = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(SAMPLE_WIDTH - 1)) begin
          state_d = iir_df1_pkg::ST_DRAIN;
        end
      end
      iir_df1_pkg::ST_DRAIN: begin
        state_d = iir_df1_pkg::ST_ROUND;
      end
      iir_df1_pkg::ST_ROUND: begin
        // Hold until the output register is free, then push the result as feedback.
        hist_ctrl.push_y = out_load;
        if (out_load) begin
          state_d = iir_df1_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = iir_df1_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= iir_df1_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  iir_df1_hist #(
    .TAPS         (TAPS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_hist (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (hist_ctrl),
    .x_new_i  (in_i.sample_in),
    .y_new_i  (sat_val),
    .x_bits_o (x_bits),
    .y_bits_o (y_bits)
  );

  iir_df1_mac #(
    .TAPS  (TAPS),
    .ACC_W (ACC_W)
  ) u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .ctrl_i      (mac_ctrl),
    .x_bits_i    (x_bits),
    .y_bits_i    (y_bits),
    .acc_o       (acc)
  );

  // Output register: parts the result from the next request's work.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_sample_q <= sat_val;
      out_clip_q   <= sat_over || sat_under;
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.sample_out = out_sample_q;
  assign out_o.clipped    = out_clip_q;

  `IIR_DF1_ASSERT_NEXT(a_accept_starts_run, clk_i, rst_ni, in_fire, state_q == iir_df1_pkg::ST_RUN && cnt_q == '0, "accepted request did not start the bit walk")
  `IIR_DF1_ASSERT_NOW(a_run_count_range, clk_i, rst_ni, state_q == iir_df1_pkg::ST_RUN, cnt_q <= CNT_W'(SAMPLE_WIDTH - 1), "bit plane counter ran past the sample width")
  `IIR_DF1_ASSERT_NEXT(a_round_fills_out, clk_i, rst_ni, out_load, out_vld_q && state_q == iir_df1_pkg::ST_IDLE, "rounded result not registered")
  `IIR_DF1_ASSERT_NOW(a_clip_at_rail, clk_i, rst_ni, out_vld_q && out_clip_q, out_sample_q == SAT_HI[SAMPLE_WIDTH-1:0] || out_sample_q == SAT_LO[SAMPLE_WIDTH-1:0], "clipped result is not at a rail")

endmodule
